// ===== hw/rtl/zone_motion_sequencer_defines.svh =====
// Assertion macros used by the checker file.
`ifndef ZONE_MOTION_SEQUENCER_DEFINES_SVH
`define ZONE_MOTION_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ZMS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("zms: %s failed", "label");

// Next-cycle implication, disabled during reset.
`define ZMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("zms: %s failed", "label");

`endif

// ===== hw/rtl/zms_pkg.sv =====
package zms_pkg;

   localparam int LIMIT_W      = 20;
   localparam int SETTING_W    = 16;
   localparam int ID_W         = 16;
   localparam int SENSOR_COUNT = 5;
   localparam int SENSOR_IDX_W = 3;
   localparam int SVEL_W       = LIMIT_W + 1;
   localparam int SDIST_W      = SETTING_W + 1;

   localparam int REQ_DATA_W = 80;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 96;
   localparam int RSP_USER_W = 2;

   localparam int CSR_INDEX_W = 1;

   localparam logic [LIMIT_W-1:0] DEFAULT_LIMIT_RESET = LIMIT_W'(10000);

   // Field positions in the response word that the checker watches.
   localparam int RSP_SV_LSB     = 0;
   localparam int RSP_SD_LSB     = SVEL_W;
   localparam int RSP_MOVING_BIT = SVEL_W + SDIST_W + 2 * LIMIT_W;

   typedef enum logic [REQ_USER_W-1:0] {
      ZONE_IDLE     = 3'd0,
      ZONE_RUN      = 3'd1,
      ZONE_STEPS    = 3'd2,
      ZONE_EYE_STOP = 3'd3
   } mode_type;

   typedef enum logic [RSP_USER_W-1:0] {
      CMD_NONE = 2'd0,
      CMD_STOP = 2'd1,
      CMD_RUN  = 2'd2,
      CMD_MOVE = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEFAULT_VELOCITY = 1'b0,
      CSR_DEFAULT_ACCEL    = 1'b1
   } csr_index_type;

   // Request word, highest field first (packed struct order).
   typedef struct packed {
      logic [3:0]              pad;
      logic [SETTING_W-1:0]    accel_setting;
      logic [SETTING_W-1:0]    velocity_setting;
      logic                    watchdog_tripped;
      logic                    steps_complete;
      logic [SENSOR_COUNT-1:0] sensor_levels;
      logic                    target_falling;
      logic [SENSOR_IDX_W-1:0] target_sensor;
      logic [SETTING_W-1:0]    move_distance;
      logic                    forward;
      logic [ID_W-1:0]         request_id;
   } req_data_type;

   // Response word, highest field first.
   typedef struct packed {
      logic                      pad;
      logic [ID_W-1:0]           ack_id;
      logic                      zone_moving;
      logic [LIMIT_W-1:0]        accel_limit;
      logic [LIMIT_W-1:0]        velocity_limit;
      logic signed [SDIST_W-1:0] signed_distance;
      logic signed [SVEL_W-1:0]  signed_velocity;
   } rsp_data_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] default_velocity;
      logic [LIMIT_W-1:0] default_accel;
   } limits_type;

endpackage

// ===== hw/rtl/zms_step.sv =====
module zms_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [zms_pkg::REQ_USER_W-1:0] zone_mode,
   input  zms_pkg::req_data_type item,
   input  zms_pkg::limits_type   limits,
   output zms_pkg::cmd_type       motor_command,
   output zms_pkg::rsp_data_type  result
);
   import zms_pkg::*;

   logic [ID_W-1:0]         last_request_ff, last_request_in;
   logic                    distance_active_ff, distance_active_in;
   logic                    edge_armed_ff, edge_armed_in;
   logic [SENSOR_IDX_W-1:0] armed_sensor_ff, armed_sensor_in;
   logic                    want_rising_ff, want_rising_in;
   logic                    previous_level_ff, previous_level_in;
   logic                    moving_ff, moving_in;
   logic [ID_W-1:0]         acked_ff, acked_in;

   logic [LIMIT_W-1:0] vlim;
   logic [LIMIT_W-1:0] alim;
   logic signed [SVEL_W-1:0]  run_velocity;
   logic signed [SDIST_W-1:0] move_steps;
   logic                      new_request;
   logic                      armed_level;

   function automatic logic level_of(logic [SENSOR_COUNT-1:0] levels,
                                     logic [SENSOR_IDX_W-1:0] idx);
      logic lv;
      lv = 1'b0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (idx == SENSOR_IDX_W'(i)) lv = levels[i];
      end
      return lv;
   endfunction

   assign vlim = (item.velocity_setting != '0) ?
                 LIMIT_W'(item.velocity_setting) : limits.default_velocity;
   assign alim = (item.accel_setting != '0) ?
                 LIMIT_W'(item.accel_setting) : limits.default_accel;
   assign run_velocity = item.forward ? $signed({1'b0, vlim}) : -$signed({1'b0, vlim});
   assign move_steps   = item.forward ? $signed({1'b0, item.move_distance})
                                      : -$signed({1'b0, item.move_distance});
   assign new_request  = (item.request_id != last_request_ff);
   assign armed_level  = level_of(item.sensor_levels, armed_sensor_ff);

   always_comb begin
      last_request_in    = last_request_ff;
      distance_active_in = distance_active_ff;
      edge_armed_in      = edge_armed_ff;
      armed_sensor_in    = armed_sensor_ff;
      want_rising_in     = want_rising_ff;
      previous_level_in  = previous_level_ff;
      moving_in          = moving_ff;
      acked_in           = acked_ff;
      motor_command      = CMD_NONE;
      result             = '0;

      if (item.watchdog_tripped) begin
         motor_command      = CMD_STOP;
         distance_active_in = 1'b0;
         edge_armed_in      = 1'b0;
         moving_in          = 1'b0;
      end else begin
         unique case (zone_mode)
            ZONE_RUN: begin
               distance_active_in     = 1'b0;
               edge_armed_in          = 1'b0;
               motor_command          = CMD_RUN;
               result.signed_velocity = run_velocity;
               moving_in              = 1'b1;
            end
            ZONE_IDLE: begin
               distance_active_in = 1'b0;
               edge_armed_in      = 1'b0;
               motor_command      = CMD_STOP;
               moving_in          = 1'b0;
            end
            ZONE_STEPS: begin
               if (new_request) begin
                  last_request_in        = item.request_id;
                  edge_armed_in          = 1'b0;
                  motor_command          = CMD_MOVE;
                  result.signed_distance = move_steps;
                  distance_active_in     = 1'b1;
                  moving_in              = 1'b1;
                  acked_in               = item.request_id;
               end else if (distance_active_ff && item.steps_complete) begin
                  distance_active_in = 1'b0;
                  moving_in          = 1'b0;
               end
            end
            ZONE_EYE_STOP: begin
               if (new_request) begin
                  last_request_in    = item.request_id;
                  distance_active_in = 1'b0;
                  want_rising_in     = !item.target_falling;
                  if (item.target_sensor >= SENSOR_IDX_W'(SENSOR_COUNT)) begin
                     // unknown target: drop to ready, leave any armed stop alone
                     moving_in = 1'b0;
                  end else begin
                     armed_sensor_in        = item.target_sensor;
                     previous_level_in      = level_of(item.sensor_levels,
                                                       item.target_sensor);
                     edge_armed_in          = 1'b1;
                     motor_command          = CMD_RUN;
                     result.signed_velocity = run_velocity;
                     moving_in              = 1'b1;
                     acked_in               = item.request_id;
                  end
               end else if (edge_armed_ff) begin
                  if (armed_level != previous_level_ff &&
                      armed_level == want_rising_ff) begin
                     edge_armed_in = 1'b0;
                     motor_command = CMD_STOP;
                     moving_in     = 1'b0;
                  end
                  previous_level_in = armed_level;
               end
            end
            default: begin
               motor_command = CMD_STOP;
               moving_in     = 1'b0;
            end
         endcase
      end

      result.velocity_limit = vlim;
      result.accel_limit    = alim;
      result.zone_moving    = moving_in;
      result.ack_id         = acked_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_request_ff    <= '0;
         distance_active_ff <= 1'b0;
         edge_armed_ff      <= 1'b0;
         armed_sensor_ff    <= '0;
         want_rising_ff     <= 1'b1;
         previous_level_ff  <= 1'b0;
         moving_ff          <= 1'b0;
         acked_ff           <= '0;
      end else if (advance) begin
         last_request_ff    <= last_request_in;
         distance_active_ff <= distance_active_in;
         edge_armed_ff      <= edge_armed_in;
         armed_sensor_ff    <= armed_sensor_in;
         want_rising_ff     <= want_rising_in;
         previous_level_ff  <= previous_level_in;
         moving_ff          <= moving_in;
         acked_ff           <= acked_in;
      end
   end

endmodule

// ===== hw/rtl/zone_motion_sequencer.sv =====
// Zone motion sequencer: one control tick per request word for one conveyor
// zone. Each accepted word yields exactly one response word carrying the
// motor command (none, stop, run at signed velocity, move signed distance),
// the velocity and acceleration limits, the zone state and the last acked
// request id. A zero speed setting falls back to the default registers at
// csr index 0 (velocity) and 1 (acceleration), both 10000 after reset; write
// them only while no word is in flight. The block takes one word per clock
// unless a stalled response holds it: an input register feeds the tick logic,
// whose state updates in the same edge that loads the response register, so a
// following word sees the new state at once. An accepted word passes from the
// input register to the response register, which drives rsp_tvalid, and a
// stalled response still lets one more word enter the input register.
module zone_motion_sequencer (
   input  logic                                 clock,
   input  logic                                 reset,
   // request word
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // tdata from bit 0: request_id[15:0], forward, move_distance[15:0],
   // target_sensor[2:0], target_falling, sensor_levels[4:0], steps_complete,
   // watchdog_tripped, velocity_setting[15:0], accel_setting[15:0], zero fill
   input  logic [zms_pkg::REQ_DATA_W-1:0]       req_tdata,
   // tuser: zone_mode[2:0]
   input  logic [zms_pkg::REQ_USER_W-1:0]       req_tuser,
   // response word
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // tdata from bit 0: signed_velocity[20:0], signed_distance[16:0],
   // velocity_limit[19:0], accel_limit[19:0], zone_moving, ack_id[15:0],
   // zero fill
   output logic [zms_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // tuser: motor_command[1:0]
   output logic [zms_pkg::RSP_USER_W-1:0]       rsp_tuser,
   // configuration writes
   input  logic                                 csr_we,
   input  logic [zms_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [zms_pkg::LIMIT_W-1:0]          csr_wdata
);
   import zms_pkg::*;

   logic                    in_valid_ff, in_valid_in;
   req_data_type            in_data_ff;
   logic [REQ_USER_W-1:0]   in_mode_ff;
   logic                    out_valid_ff, out_valid_in;
   rsp_data_type            out_data_ff;
   cmd_type                 out_cmd_ff;
   limits_type              limits_ff;

   logic         out_free;
   logic         advance;
   logic         req_take;
   cmd_type      step_cmd;
   rsp_data_type step_result;

   // Response slot is free when empty or being drained this cycle.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take)     in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;

      out_valid_in = out_valid_ff;
      if (advance)         out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the incoming word.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data_type'(req_tdata);
         in_mode_ff <= req_tuser;
      end
   end

   // Hold the finished word until the sink takes it.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= step_result;
         out_cmd_ff  <= step_cmd;
      end
   end

   // Default limit registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.default_velocity <= DEFAULT_LIMIT_RESET;
         limits_ff.default_accel    <= DEFAULT_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEFAULT_VELOCITY: limits_ff.default_velocity <= csr_wdata;
            CSR_DEFAULT_ACCEL:    limits_ff.default_accel    <= csr_wdata;
            default: ;
         endcase
      end
   end

   zms_step u_step (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .zone_mode     (in_mode_ff),
      .item          (in_data_ff),
      .limits        (limits_ff),
      .motor_command (step_cmd),
      .result        (step_result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_data_ff);
   assign rsp_tuser  = RSP_USER_W'(out_cmd_ff);

endmodule

// ===== hw/rtl/zms_checker.sv =====
`include "zone_motion_sequencer_defines.svh"

module zms_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [zms_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [zms_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import zms_pkg::*;

   logic [SVEL_W-1:0]  sv_field;
   logic [SDIST_W-1:0] sd_field;
   logic               moving_bit;
   logic               rsp_stalled;
   logic               motion_cmd;
   logic               stop_cmd;
   logic               unused_zero;
   logic [RSP_USER_W+RSP_DATA_W-1:0] rsp_word;

   assign sv_field    = rsp_tdata[RSP_SV_LSB +: SVEL_W];
   assign sd_field    = rsp_tdata[RSP_SD_LSB +: SDIST_W];
   assign moving_bit  = rsp_tdata[RSP_MOVING_BIT];
   assign rsp_stalled = rsp_tvalid && !rsp_tready;
   assign motion_cmd  = (rsp_tuser == CMD_RUN) || (rsp_tuser == CMD_MOVE);
   assign stop_cmd    = (rsp_tuser == CMD_STOP);
   assign unused_zero = (rsp_tuser == CMD_RUN || sv_field == '0) &&
                        (rsp_tuser == CMD_MOVE || sd_field == '0);
   assign rsp_word    = {rsp_tuser, rsp_tdata};

   // A stalled response word holds.
   `ZMS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stalled, rsp_tvalid && $stable(rsp_word))

   // Run and move commands leave the zone moving, a stop leaves it ready.
   `ZMS_ASSERT_NOW(a_run_moves, clock, reset, rsp_tvalid && motion_cmd, moving_bit)
   `ZMS_ASSERT_NOW(a_stop_ready, clock, reset, rsp_tvalid && stop_cmd, !moving_bit)

   // Signed fields are zero unless their command uses them.
   `ZMS_ASSERT_NOW(a_unused_zero, clock, reset, rsp_tvalid, unused_zero)

endmodule

bind zone_motion_sequencer zms_checker u_zms_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
